/* rtl/wfm_pkg.sv */
// shared types and constants for the waveform frame measure block
// no dependencies
package wfm_pkg;

   localparam int FRAME_SAMPLES  = 192;
   localparam int SCREEN_COLUMNS = 96;
   localparam int PAIRS          = SCREEN_COLUMNS / 2;
   localparam int ADDR_W         = $clog2(FRAME_SAMPLES);
   localparam int CNT_W          = $clog2(FRAME_SAMPLES + 1);
   localparam int PAIR_W         = 6;
   localparam int LAST_ADDR      = FRAME_SAMPLES - 1;

   localparam logic [0:0] CSR_TIME_SCALE = 1'd0;
   localparam logic [0:0] CSR_VERT_OFF   = 1'd1;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MID,
      ST_SCAN_ADDR,
      ST_SCAN,
      ST_PERIOD,
      ST_DIV,
      ST_VPP,
      ST_ROW_A,
      ST_ROW_B,
      ST_ROW_C,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;        // store sample, update min/max
      logic calc_mid;
      logic scan_start;  // set up crossing scan
      logic scan_step;
      logic period;      // set up frequency divide
      logic div_step;
      logic vpp_start;
      logic row_addr0;   // issue read for column 2k
      logic row_addr1;   // issue read for column 2k+1, capture first
      logic row_cap1;    // capture second
      logic emit;        // result taken, advance pair
   } cmd_type;

   typedef struct packed {
      logic frame_full;
      logic scan_done;
      logic div_done;
      logic last_pair;
   } sts_type;

endpackage

/* rtl/wfm_ram.sv */
// generic single-port write, single-port read ram with registered read
// no dependencies
module wfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/wfm_datapath.sv */
// datapath: sample store, min/max, crossing scan, serial divider, screen rows
// depends on wfm_pkg and wfm_ram
module wfm_datapath
   import wfm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [7:0]       sample,
   input  logic [2:0]       time_scale,
   input  logic [5:0]       vert_off,
   output logic [PAIR_W-1:0] column_pair,
   output logic [7:0]       row_first,
   output logic [7:0]       row_second,
   output logic [7:0]       sample_max,
   output logic [7:0]       sample_min,
   output logic [7:0]       sample_mid,
   output logic [7:0]       start_index,
   output logic [7:0]       end_index,
   output logic [12:0]      vpp_millivolts,
   output logic [12:0]      freq_khz_q8,
   output logic             period_found
);
   logic [CNT_W-1:0]  load_cnt_ff;
   logic [7:0]        max_ff, min_ff, mid_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [ADDR_W-1:0] scan_ff;     // index of sample now on rd_data
   logic [7:0]        prev_ff;
   logic              prev_ok_ff;
   logic              first_ff, found_ff, scan_done_ff;
   logic [ADDR_W:0]   start_ff, end_ff;
   // restoring divider, 13-bit quotient
   logic [23:0]       rem_ff;
   logic [23:0]       dvs_ff;
   logic [12:0]       quo_ff;
   logic [4:0]        dcnt_ff;
   logic [12:0]       freq_ff, vpp_ff;
   logic [39:0]       vpp_prod;
   logic [PAIR_W-1:0] pair_ff;
   logic [7:0]        row0_ff, row1_ff;
   logic [ADDR_W:0]   col;

   wfm_ram #(.WIDTH(8), .DEPTH(FRAME_SAMPLES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (load_cnt_ff[ADDR_W-1:0]),
      .wr_data (sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // column index modulo frame length, single subtract suffices
   always_comb begin
      col = '0;
      col = {pair_ff, 1'b0} + (cmd.row_addr1 ? 1'b1 : 1'b0);
      if (col >= (ADDR_W+1)'(FRAME_SAMPLES)) col = col - (ADDR_W+1)'(FRAME_SAMPLES);
      if (cmd.row_addr0 || cmd.row_addr1) rd_addr = col[ADDR_W-1:0];
      else if (cmd.scan_start)            rd_addr = '0;
      else                                rd_addr = scan_ff + 1'b1;
   end

   // peak-to-peak: (max - min) * 5000 / 255 = d * 1000 / 51, times 2^24/51
   // rounded up, exact for every d up to 255
   assign vpp_prod = 40'(max_ff - min_ff) * 40'd328966000;

   function automatic logic [7:0] row_of(input logic [7:0] s, input logic [7:0] m,
                                         input logic [5:0] off);
      logic signed [9:0] d, q, r;
      d = $signed({2'b00, m}) - $signed({2'b00, s});
      q = (d < 0) ? -((-d) >>> 2) : (d >>> 2);
      r = 10'sd32 + q + $signed({{4{off[5]}}, off});
      return r[7:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         max_ff      <= 8'd0;
         min_ff      <= 8'd255;
         dcnt_ff     <= '0;
      end else begin
         if (cmd.load) begin
            load_cnt_ff <= load_cnt_ff + 1'b1;
            if (sample > max_ff) max_ff <= sample;
            if (sample < min_ff) min_ff <= sample;
         end
         if (cmd.calc_mid) begin
            mid_ff      <= 8'(({1'b0, max_ff} + {1'b0, min_ff}) >> 1);
            load_cnt_ff <= '0;
         end
         if (cmd.emit && sts.last_pair) begin
            max_ff <= 8'd0;
            min_ff <= 8'd255;
         end
         if (cmd.period) dcnt_ff <= 5'd13;
         else if (cmd.div_step && dcnt_ff != 0) dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   // crossing scan: one sample per cycle from the store
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_ff      <= '0;
         prev_ok_ff   <= 1'b0;
         first_ff     <= 1'b0;
         found_ff     <= 1'b0;
         scan_done_ff <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
      end else if (cmd.scan_step && !scan_done_ff) begin
         prev_ff    <= rd_data;
         prev_ok_ff <= 1'b1;
         scan_ff    <= scan_ff + 1'b1;
         if (prev_ok_ff && prev_ff < mid_ff && rd_data >= mid_ff) begin
            if (!first_ff) begin
               first_ff <= 1'b1;
               start_ff <= {1'b0, scan_ff};
               end_ff   <= {1'b0, scan_ff};
            end else if ({1'b0, scan_ff} > start_ff + 1'b1) begin
               found_ff     <= 1'b1;
               end_ff       <= {1'b0, scan_ff};
               scan_done_ff <= 1'b1;
            end
         end
         if (scan_ff == ADDR_W'(LAST_ADDR)) scan_done_ff <= 1'b1;
      end
      if (cmd.period) begin
         rem_ff <= 24'd4096;
         dvs_ff <= 24'(end_ff - start_ff) *
                   24'((time_scale == 3'd0) ? 3'd1 : time_scale);
         quo_ff <= '0;
      end else if (cmd.div_step && dcnt_ff != 0) begin
         if (rem_ff >= (dvs_ff << (dcnt_ff - 1'b1))) begin
            rem_ff <= rem_ff - (dvs_ff << (dcnt_ff - 1'b1));
            quo_ff <= quo_ff | (13'd1 << (dcnt_ff - 1'b1));
         end
      end else if (cmd.div_step) begin
         freq_ff <= found_ff ? quo_ff : 13'd0;
      end
      if (cmd.vpp_start) vpp_ff <= vpp_prod[36:24];
      if (cmd.period) pair_ff <= '0;
      else if (cmd.emit) pair_ff <= pair_ff + 1'b1;
      if (cmd.row_addr1) row0_ff <= row_of(rd_data, mid_ff, vert_off);
      if (cmd.row_cap1)  row1_ff <= row_of(rd_data, mid_ff, vert_off);
   end

   assign sts.frame_full = (load_cnt_ff == CNT_W'(FRAME_SAMPLES));
   assign sts.scan_done  = scan_done_ff;
   assign sts.div_done   = (dcnt_ff == 0);
   assign sts.last_pair  = (pair_ff == PAIR_W'(PAIRS - 1));

   assign column_pair    = pair_ff;
   assign row_first      = row0_ff;
   assign row_second     = row1_ff;
   assign sample_max     = max_ff;
   assign sample_min     = min_ff;
   assign sample_mid     = mid_ff;
   assign start_index    = 8'(start_ff);
   assign end_index      = 8'(end_ff);
   assign vpp_millivolts = vpp_ff;
   assign freq_khz_q8    = freq_ff;
   assign period_found   = found_ff;
endmodule

/* rtl/wfm_ctrl.sv */
// controller state machine sequencing load, scan, divides and result output
// depends on wfm_pkg
module wfm_ctrl
   import wfm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output logic    rsp_tlast,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:      if (sts.frame_full) state_in = ST_MID;
         ST_MID:       state_in = ST_SCAN_ADDR;
         ST_SCAN_ADDR: state_in = ST_SCAN;
         ST_SCAN:      if (sts.scan_done) state_in = ST_PERIOD;
         ST_PERIOD:    state_in = ST_DIV;
         ST_DIV:       if (sts.div_done) state_in = ST_VPP;
         ST_VPP:       state_in = ST_ROW_A;
         ST_ROW_A:     state_in = ST_ROW_B;
         ST_ROW_B:     state_in = ST_ROW_C;
         ST_ROW_C:     state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_tready) state_in = sts.last_pair ? ST_LOAD : ST_ROW_A;
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = !sts.frame_full;
            cmd.load   = req_tvalid && !sts.frame_full;
         end
         ST_MID:       cmd.calc_mid   = 1'b1;
         ST_SCAN_ADDR: cmd.scan_start = 1'b1;
         ST_SCAN:      cmd.scan_step  = 1'b1;
         ST_PERIOD:    cmd.period     = 1'b1;
         ST_DIV:       cmd.div_step   = 1'b1;
         ST_VPP:       cmd.vpp_start  = 1'b1;
         ST_ROW_A:     cmd.row_addr0  = 1'b1;
         ST_ROW_B:     cmd.row_addr1  = 1'b1;
         ST_ROW_C:     cmd.row_cap1   = 1'b1;
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = sts.last_pair;
            cmd.emit   = rsp_tready;
         end
         default: ;
      endcase
   end

   // no sample is taken while results are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input accepted during output");
   // a frame's results end on the last pair
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> state_ff == ST_LOAD)
      else $error("frame did not end after last result");
   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
endmodule

/* rtl/waveform_frame_measure.sv */
// top level of the waveform frame measure block
// depends on wfm_pkg, wfm_ctrl, wfm_datapath, wfm_ram
//
// usage:
//  - req channel: one 8-bit adc sample per transaction, tdata[7:0] = sample
//  - a frame is 192 samples, loaded one per cycle into the sample store
//  - after the last sample the block scans the store for midpoint crossings,
//    runs a 13-step serial divide for the frequency and takes peak-to-peak
//    from one reciprocal multiply, then emits 48 rsp transactions, one per
//    column pair
//  - each rsp transaction needs two store reads plus the offer, since the
//    sample store has a single read port
//  - rsp tlast marks the final column pair of the frame
//  - req_tready is low from the last sample until the last result is taken
//  - a stalled rsp holds its transaction until rsp_tready
//  - csr channel writes time_scale_code (index 0) or vertical_offset
//    (index 1); it is always ready and should be used only when idle
//  - synchronous reset clears the load and divide counters, min/max, the state
//    machine and csr values; store contents are not cleared
module waveform_frame_measure
   import wfm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // column_pair[5:0], row_first[13:6], row_second[21:14], sample_max[29:22],
   // sample_min[37:30], sample_mid[45:38], start_index[53:46], end_index[61:54],
   // vpp_millivolts[74:62], freq_khz_q8[87:75], zero fill [95:88]
   output logic [95:0] rsp_tdata,
   output logic        rsp_tuser,   // period_found
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic [2:0] scale_ff;
   logic [5:0] offset_ff;
   logic [PAIR_W-1:0] column_pair;
   logic [7:0]  row_first, row_second, smax, smin, smid, sidx, eidx;
   logic [12:0] vpp, freq;
   logic        found;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= 3'd1;
         offset_ff <= 6'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIME_SCALE: scale_ff  <= csr_data[2:0];
            CSR_VERT_OFF:   offset_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   wfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .sts        (sts),
      .cmd        (cmd)
   );

   wfm_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .sample         (req_tdata),
      .time_scale     (scale_ff),
      .vert_off       (offset_ff),
      .column_pair    (column_pair),
      .row_first      (row_first),
      .row_second     (row_second),
      .sample_max     (smax),
      .sample_min     (smin),
      .sample_mid     (smid),
      .start_index    (sidx),
      .end_index      (eidx),
      .vpp_millivolts (vpp),
      .freq_khz_q8    (freq),
      .period_found   (found)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {8'd0, freq, vpp, eidx, sidx, smid, smin, smax,
                       row_second, row_first, column_pair};
   assign rsp_tuser = found;
endmodule
